// ----- rtl/core/mlqt_pkg.sv -----
// Shared types, constants and the encoder decode table for the motor link block.
`timescale 1ns / 1ps
`default_nettype none

package mlqt_pkg;

   // Channel and register widths
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 24;
   localparam int QUEUE_DEPTH_DEF = 2;

   // Input kinds carried in req_tuser
   localparam logic [1:0] MODE_ENC  = 2'd0;
   localparam logic [1:0] MODE_TICK = 2'd1;
   localparam logic [1:0] MODE_CMD  = 2'd2;

   // Register indexes
   localparam logic CSR_FRAME_PERIOD = 1'b0;
   localparam logic CSR_TIMEOUT      = 1'b1;

   localparam logic [7:0] FRAME_PERIOD_RST = 8'd20;
   localparam logic [7:0] TIMEOUT_RST      = 8'd50;
   localparam logic [7:0] CMD_CLEAR_FAULT  = 8'h80;
   localparam logic [7:0] REPLY_TIMEOUT    = 8'hFF;
   localparam logic [7:0] STATUS_FAULT     = 8'h80;
   localparam logic [1:0] FAULT_NONE       = 2'd0;
   localparam logic [1:0] FAULT_POWER_ON   = 2'd1;
   localparam logic [1:0] FAULT_TIMEOUT    = 2'd2;
   localparam logic [1:0] BEAT_LAST        = 2'd3;

   typedef enum logic [2:0] {
      PH_FRAME,
      PH_WAIT,
      PH_EARLY,
      PH_LATE,
      PH_DISCARD,
      PH_RESYNC
   } phase_type;

   typedef enum logic [1:0] {
      ENC_NONE,
      ENC_UP,
      ENC_DOWN,
      ENC_MISS
   } enc_act_type;

   // One unit of back-end work: a four-byte report or a single drive update
   typedef struct packed {
      logic        frame;
      logic [15:0] pos;
      logic [7:0]  miss;
      logic [7:0]  status;
      logic [7:0]  duty;
      logic        dir;
   } job_type;

   // Index is {B, A, prev B, prev A}
   function automatic enc_act_type enc_action(input logic [3:0] idx);
      enc_act_type act;
      unique case (idx)
         4'd0:  act = ENC_NONE;
         4'd1:  act = ENC_UP;
         4'd2:  act = ENC_DOWN;
         4'd3:  act = ENC_MISS;
         4'd4:  act = ENC_DOWN;
         4'd5:  act = ENC_NONE;
         4'd6:  act = ENC_MISS;
         4'd7:  act = ENC_UP;
         4'd8:  act = ENC_UP;
         4'd9:  act = ENC_MISS;
         4'd10: act = ENC_NONE;
         4'd11: act = ENC_DOWN;
         4'd12: act = ENC_MISS;
         4'd13: act = ENC_DOWN;
         4'd14: act = ENC_UP;
         default: act = ENC_NONE;
      endcase
      return act;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mlqt_front.sv -----
// Front end: updates encoder, timer and link state per event; queues report/drive jobs.
`timescale 1ns / 1ps
`default_nettype none

module mlqt_front
   import mlqt_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_fire,
   input  wire logic [1:0]       mode,
   input  wire logic             pin_a,
   input  wire logic             pin_b,
   input  wire logic [7:0]       rx_byte,
   input  wire logic             csr_wen,
   input  wire logic             csr_index,
   input  wire logic [7:0]       csr_wdata,
   output logic                  job_push,
   output job_type               job
);

   logic [7:0]  period_ff, timeout_ff;
   logic [15:0] pos_ff, pos_in;
   logic [7:0]  miss_ff, miss_in;
   logic [1:0]  prev_ff, prev_in;
   logic [7:0]  ms_ff, ms_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [1:0]  fault_ff, fault_in;
   logic [7:0]  rt_ff, rt_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  held_ff, held_in;
   logic        hv_ff, hv_in;
   logic [7:0]  duty_ff, duty_in;
   logic        dir_ff, dir_in;
   enc_act_type act;

   always_comb begin
      pos_in   = pos_ff;
      miss_in  = miss_ff;
      prev_in  = prev_ff;
      ms_in    = ms_ff;
      cmd_in   = cmd_ff;
      fault_in = fault_ff;
      rt_in    = rt_ff;
      phase_in = phase_ff;
      held_in  = held_ff;
      hv_in    = hv_ff;
      duty_in  = duty_ff;
      dir_in   = dir_ff;
      job_push = 1'b0;
      job      = '0;
      act      = enc_action({pin_b, pin_a, prev_ff});

      if (req_fire) begin
         unique case (mode)
            MODE_ENC: begin
               prev_in = {pin_b, pin_a};
               case (act)
                  ENC_UP:   pos_in  = pos_ff + 16'd1;
                  ENC_DOWN: pos_in  = pos_ff - 16'd1;
                  ENC_MISS: miss_in = miss_ff + 8'd1;
                  default: ;
               endcase
            end
            MODE_TICK: begin
               ms_in = ms_ff + 8'd1;
               case (phase_ff) inside
                  PH_WAIT: begin
                     if (ms_in >= timeout_ff) begin
                        if (fault_ff == FAULT_NONE) fault_in = FAULT_TIMEOUT;
                        rt_in    = REPLY_TIMEOUT;
                        duty_in  = '0;
                        phase_in = PH_DISCARD;
                        job_push = 1'b1;
                        job.dir  = dir_ff;
                     end
                  end
                  PH_EARLY: begin
                     if (ms_in == period_ff) begin
                        ms_in    = '0;
                        phase_in = PH_FRAME;
                     end
                  end
                  PH_LATE, PH_RESYNC: begin
                     ms_in    = '0;
                     phase_in = PH_FRAME;
                  end
                  default: ;
               endcase
            end
            MODE_CMD: begin
               if (phase_ff == PH_WAIT) begin
                  cmd_in   = rx_byte;
                  rt_in    = ms_ff;
                  phase_in = (ms_ff < period_ff) ? PH_EARLY : PH_LATE;
               end else if (phase_ff == PH_DISCARD) begin
                  cmd_in   = '0;
                  phase_in = PH_RESYNC;
               end else if (!hv_ff) begin
                  held_in = rx_byte;
                  hv_in   = 1'b1;
               end
            end
            default: ;
         endcase

         if (phase_in == PH_FRAME) begin
            dir_in  = cmd_in[7];
            duty_in = (fault_in != FAULT_NONE) ? 8'd0 : {cmd_in[6:0], 1'b0};
            if (cmd_in == CMD_CLEAR_FAULT) fault_in = FAULT_NONE;
            job_push   = 1'b1;
            job.frame  = 1'b1;
            job.pos    = pos_in;
            job.miss   = miss_in;
            job.status = (fault_in != FAULT_NONE) ? (STATUS_FAULT | {6'd0, fault_in}) : rt_in;
            job.duty   = duty_in;
            job.dir    = dir_in;
            phase_in   = PH_WAIT;
            // a byte parked outside the wait counts as the command right away
            if (hv_in) begin
               hv_in    = 1'b0;
               cmd_in   = held_in;
               rt_in    = ms_in;
               phase_in = (ms_in < period_ff) ? PH_EARLY : PH_LATE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= FRAME_PERIOD_RST;
         timeout_ff <= TIMEOUT_RST;
         pos_ff     <= '0;
         miss_ff    <= '0;
         prev_ff    <= '0;
         ms_ff      <= '0;
         cmd_ff     <= '0;
         fault_ff   <= FAULT_POWER_ON;
         rt_ff      <= '0;
         phase_ff   <= PH_FRAME;
         hv_ff      <= 1'b0;
         duty_ff    <= '0;
         dir_ff     <= 1'b0;
      end else begin
         if (csr_wen) begin
            unique case (csr_index)
               CSR_FRAME_PERIOD: period_ff  <= csr_wdata;
               CSR_TIMEOUT:      timeout_ff <= csr_wdata;
               default: ;
            endcase
         end
         pos_ff   <= pos_in;
         miss_ff  <= miss_in;
         prev_ff  <= prev_in;
         ms_ff    <= ms_in;
         cmd_ff   <= cmd_in;
         fault_ff <= fault_in;
         rt_ff    <= rt_in;
         phase_ff <= phase_in;
         hv_ff    <= hv_in;
         duty_ff  <= duty_in;
         dir_ff   <= dir_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

`default_nettype wire

// ----- rtl/core/mlqt_queue.sv -----
// Small job queue between the front end and the report sender.
`timescale 1ns / 1ps
`default_nettype none

module mlqt_queue
   import mlqt_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  job_type      push_job,
   input  wire logic    pop,
   output logic         full,
   output logic         head_valid,
   output job_type      head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push)
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         if (pop)
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_job;
   end

endmodule

`default_nettype wire

// ----- rtl/core/mlqt_back.sv -----
// Back end: expands queued jobs into result transfers through an output register.
`timescale 1ns / 1ps
`default_nettype none

module mlqt_back
   import mlqt_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   head_valid,
   input  job_type                     head,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                        rsp_tlast,
   output logic                        rsp_tuser
);

   job_type     job_ff, job_in;
   logic        act_ff, act_in;
   logic [1:0]  beat_ff, beat_in;
   logic        valid_ff, valid_in;
   logic [7:0]  tx_ff, tx_in;
   logic [7:0]  duty_ff, duty_in;
   logic        dir_ff, dir_in;
   logic        last_ff, last_in;
   logic        has_ff, has_in;
   job_type     src;
   logic [1:0]  src_beat;
   logic        load;

   assign load = !valid_ff || rsp_tready;

   always_comb begin
      job_in   = job_ff;
      act_in   = act_ff;
      beat_in  = beat_ff;
      valid_in = valid_ff;
      pop      = 1'b0;
      src      = act_ff ? job_ff : head;
      src_beat = act_ff ? beat_ff : 2'd0;
      tx_in    = tx_ff;
      duty_in  = duty_ff;
      dir_in   = dir_ff;
      last_in  = last_ff;
      has_in   = has_ff;

      if (load) begin
         valid_in = act_ff || head_valid;
         if (!act_ff && head_valid) begin
            pop = 1'b1;
            if (head.frame) begin
               job_in  = head;
               act_in  = 1'b1;
               beat_in = 2'd1;
            end
         end else if (act_ff) begin
            beat_in = beat_ff + 2'd1;
            if (beat_ff == BEAT_LAST) act_in = 1'b0;
         end
         duty_in = src.duty;
         dir_in  = src.dir;
         has_in  = src.frame;
         last_in = src.frame && (src_beat == BEAT_LAST);
         if (!src.frame) begin
            tx_in = '0;
         end else begin
            case (src_beat)
               2'd0:    tx_in = src.pos[7:0];
               2'd1:    tx_in = src.pos[15:8];
               2'd2:    tx_in = src.miss;
               default: tx_in = src.status;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff   <= 1'b0;
         beat_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         act_ff   <= act_in;
         beat_ff  <= beat_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      tx_ff   <= tx_in;
      duty_ff <= duty_in;
      dir_ff  <= dir_in;
      last_ff <= last_in;
      has_ff  <= has_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, dir_ff, duty_ff, tx_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = has_ff;

endmodule

`default_nettype wire

// ----- rtl/core/motor_link_with_quadrature_telemetry.sv -----
// Top level of the motor link with quadrature telemetry.
//
//   channel  dir  handshake              payload
//   req_     in   tvalid/tready          tuser: mode; tdata: pin_a, pin_b, rx_byte
//   rsp_     out  tvalid/tready          tuser: has_byte; tlast: last_byte;
//                                        tdata: tx_byte, pwm_duty, reverse
//   csr_     in   wen (no wait)          index 0 frame_period_ms, 1 timeout_ms
//
// The front end handles every input transfer as it is accepted; a frame start queues a
// four-byte report, a timeout one drive update. The back end sends one result per cycle
// while rsp_tready is high, through the single output register. req_tready drops only
// while the job queue is full. Reset is synchronous and leaves a frame start pending:
// the first input transfer, of any kind, also starts a frame.
`timescale 1ns / 1ps
`default_nettype none

module motor_link_with_quadrature_telemetry
   import mlqt_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,   // pin_a, pin_b, rx_byte[7:0], pad
   input  wire logic [1:0]             req_tuser,   // mode
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,   // tx_byte, pwm_duty, reverse, pad
   output logic                        rsp_tlast,
   output logic                        rsp_tuser,   // has_byte
   input  wire logic                   csr_wen,
   input  wire logic                   csr_index,
   input  wire logic [7:0]             csr_wdata
);

   logic    req_fire;
   logic    job_push;
   job_type job;
   logic    q_full, q_head_valid, q_pop;
   job_type q_head;

   assign req_tready = !q_full;
   assign req_fire   = req_tvalid && req_tready;

   mlqt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .mode      (req_tuser),
      .pin_a     (req_tdata[0]),
      .pin_b     (req_tdata[1]),
      .rx_byte   (req_tdata[9:2]),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .job_push  (job_push),
      .job       (job)
   );

   mlqt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (job),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head       (q_head)
   );

   mlqt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head       (q_head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ----- rtl/core/mlqt_checker.sv -----
// Port-level checks for the motor link, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mlqt_checker
   import mlqt_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                   rsp_tlast,
   input wire logic                   rsp_tuser
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)
         && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_last_is_report: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("status marker on a drive-only update");

   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[15:0] == 16'd0)
      else $error("timeout update with nonzero byte or duty");

   a_duty_even: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[8])
      else $error("odd duty value");

endmodule

bind motor_link_with_quadrature_telemetry mlqt_checker u_mlqt_checker (.*);

`default_nettype wire

// ----- verif/tb_motor_link_with_quadrature_telemetry.sv -----
// Self-checking testbench for the motor link with quadrature telemetry block.
`timescale 1ns / 1ps

module tb_motor_link_with_quadrature_telemetry;
   import mlqt_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int MAX_REPORTED = 10;
   localparam int HOLDOFF_CYCLES = 200;
   localparam int SETTLE_CYCLES = 16;
   localparam int TICK_RUN_MAX = 40;
   localparam int NUM_PHASES = 8;

   typedef struct packed {
      logic [1:0] mode;
      logic       pin_a;
      logic       pin_b;
      logic [7:0] rx;
   } link_event_type;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] tx;
      logic       last;
      logic [7:0] duty;
      logic       rev;
   } link_beat_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // pin_a, pin_b, rx_byte[7:0], pad
   logic [1:0]             req_tuser = '0;   // mode
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // tx_byte[7:0], pwm_duty[7:0], reverse, pad
   logic                   rsp_tlast;
   logic                   rsp_tuser;        // has_byte
   logic                   csr_wen = 1'b0;
   logic                   csr_index = CSR_FRAME_PERIOD;
   logic [7:0]             csr_wdata = '0;

   motor_link_with_quadrature_telemetry u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

   // Stimulus and result stores
   link_event_type event_queue[$];
   link_event_type cur_event;
   link_beat_type  beats_due[$];
   int          events_in_flight = 0;
   int          fail_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          holdoff_left = 0;
   int          holdoff_asked = 0;
   int          holdoff_done = 0;
   logic [1:0]  gen_lines = 2'b00;

   // Predicted block state
   logic [7:0]  period_ms;
   logic [7:0]  timeout_lim;
   logic [15:0] enc_position;
   logic [7:0]  enc_misses;
   logic [1:0]  enc_lines;
   logic [7:0]  tick_count;
   logic [7:0]  last_cmd;
   logic [1:0]  fault_code;
   logic [7:0]  reply_ms;
   phase_type   link_phase;
   logic [7:0]  held_cmd;
   logic        held_full;
   logic [7:0]  drive_duty;
   logic        drive_rev;

   task automatic link_model_reset();
      period_ms    = FRAME_PERIOD_RST;
      timeout_lim  = TIMEOUT_RST;
      enc_position = '0;
      enc_misses   = '0;
      enc_lines    = '0;
      tick_count   = '0;
      last_cmd     = '0;
      fault_code   = FAULT_POWER_ON;
      reply_ms     = '0;
      link_phase   = PH_FRAME;
      held_cmd     = '0;
      held_full    = 1'b0;
      drive_duty   = '0;
      drive_rev    = 1'b0;
   endtask

   // Position along the quadrature cycle; forward motion lowers the rank by one
   function automatic logic [1:0] gray_rank(input logic [1:0] g);
      return {g[1], g[1] ^ g[0]};
   endfunction

   task automatic note_beat(input logic has, input logic [7:0] tx, input logic last);
      link_beat_type b;
      b.has_byte = has;
      b.tx       = tx;
      b.last     = last;
      b.duty     = drive_duty;
      b.rev      = drive_rev;
      beats_due.push_back(b);
   endtask

   task automatic take_command(input logic [7:0] b);
      last_cmd = b;
      reply_ms = tick_count;
      link_phase = (tick_count < period_ms) ? PH_EARLY : PH_LATE;
   endtask

   task automatic link_model_step(input link_event_type ev);
      logic [1:0] lines;
      logic [1:0] step;
      logic [7:0] status;
      lines = {ev.pin_b, ev.pin_a};
      case (ev.mode)
         MODE_ENC: begin
            step = gray_rank(enc_lines) - gray_rank(lines);
            if ((lines ^ enc_lines) == 2'b11) enc_misses = enc_misses + 8'd1;
            else if (step == 2'd1) enc_position = enc_position + 16'd1;
            else if (step == 2'd3) enc_position = enc_position - 16'd1;
            enc_lines = lines;
         end
         MODE_TICK: begin
            tick_count = tick_count + 8'd1;
            if (link_phase == PH_WAIT) begin
               if (tick_count >= timeout_lim) begin
                  if (fault_code == FAULT_NONE) fault_code = FAULT_TIMEOUT;
                  reply_ms = REPLY_TIMEOUT;
                  drive_duty = '0;
                  link_phase = PH_DISCARD;
                  note_beat(1'b0, 8'h00, 1'b0);
               end
            end else if (link_phase == PH_EARLY) begin
               if (tick_count == period_ms) begin
                  tick_count = '0;
                  link_phase = PH_FRAME;
               end
            end else if (link_phase == PH_LATE || link_phase == PH_RESYNC) begin
               tick_count = '0;
               link_phase = PH_FRAME;
            end
         end
         MODE_CMD: begin
            if (link_phase == PH_WAIT) begin
               take_command(ev.rx);
            end else if (link_phase == PH_DISCARD) begin
               last_cmd = '0;
               link_phase = PH_RESYNC;
            end else if (!held_full) begin
               held_cmd = ev.rx;
               held_full = 1'b1;
            end
         end
         default: ;
      endcase

      if (link_phase == PH_FRAME) begin
         drive_rev = last_cmd[7];
         drive_duty = (fault_code != FAULT_NONE) ? 8'h00 : {last_cmd[6:0], 1'b0};
         if (last_cmd == CMD_CLEAR_FAULT) fault_code = FAULT_NONE;
         status = (fault_code != FAULT_NONE) ? (STATUS_FAULT | {6'b0, fault_code}) : reply_ms;
         note_beat(1'b1, enc_position[7:0], 1'b0);
         note_beat(1'b1, enc_position[15:8], 1'b0);
         note_beat(1'b1, enc_misses, 1'b0);
         note_beat(1'b1, status, 1'b1);
         link_phase = PH_WAIT;
         if (held_full) begin
            held_full = 1'b0;
            take_command(held_cmd);
         end
      end
   endtask

   task automatic flag_error(input string what, input int want, input int got);
      if (fail_count < MAX_REPORTED)
         $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
      fail_count++;
   endtask

   task automatic check_beat();
      link_beat_type want;
      if (beats_due.size() == 0) begin
         flag_error("unexpected transfer, tdata", 0, rsp_tdata);
      end else begin
         want = beats_due.pop_front();
         if (rsp_tuser !== want.has_byte) flag_error("has_byte", want.has_byte, rsp_tuser);
         if (rsp_tdata[7:0] !== want.tx) flag_error("tx_byte", want.tx, rsp_tdata[7:0]);
         if (rsp_tlast !== want.last) flag_error("last_byte", want.last, rsp_tlast);
         if (rsp_tdata[15:8] !== want.duty) flag_error("pwm_duty", want.duty, rsp_tdata[15:8]);
         if (rsp_tdata[16] !== want.rev) flag_error("reverse", want.rev, rsp_tdata[16]);
      end
   endtask

   // Request side: prediction happens on the transfer
   always @(posedge clock) begin : drive_req
      link_event_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            link_model_step(cur_event);
            events_in_flight--;
         end
         if (!req_tvalid || req_tready) begin
            if (event_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = event_queue.pop_front();
               cur_event = nxt;
               req_tvalid <= 1'b1;
               req_tuser <= nxt.mode;
               req_tdata <= {6'b0, nxt.rx, nxt.pin_b, nxt.pin_a};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_beat();
         rsp_tready <= (holdoff_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Long receiver hold-off so the job queue fills and req_tready drops
   always @(posedge clock) begin
      if (reset) begin
         holdoff_left <= 0;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
      end else if (holdoff_asked != holdoff_done) begin
         holdoff_left <= HOLDOFF_CYCLES;
         holdoff_done <= holdoff_asked;
      end
   end

   task automatic queue_event(input logic [1:0] mode, input logic a, input logic b,
                              input logic [7:0] rx);
      link_event_type ev;
      ev.mode  = mode;
      ev.pin_a = a;
      ev.pin_b = b;
      ev.rx    = rx;
      events_in_flight++;
      event_queue.push_back(ev);
   endtask

   task automatic queue_tick();
      queue_event(MODE_TICK, 1'($urandom), 1'($urandom), 8'($urandom));
   endtask

   task automatic queue_cmd(input logic [7:0] b);
      queue_event(MODE_CMD, 1'($urandom), 1'($urandom), b);
   endtask

   task automatic queue_enc(input logic b, input logic a);
      queue_event(MODE_ENC, a, b, 8'($urandom));
   endtask

   // Mostly single-line changes, some double changes and repeats
   task automatic queue_enc_step();
      int r;
      r = $urandom_range(19);
      if (r < 17) gen_lines = gen_lines ^ (($urandom_range(1) == 0) ? 2'b01 : 2'b10);
      else if (r == 17) gen_lines = gen_lines ^ 2'b11;
      queue_enc(gen_lines[1], gen_lines[0]);
   endtask

   task automatic queue_traffic(input int budget, input int per, input int tmo);
      int pushed;
      int k;
      int pick;
      pushed = 0;
      while (pushed < budget) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            // command, a little encoder motion, then ticks toward the next frame
            queue_cmd(($urandom_range(3) == 0) ? CMD_CLEAR_FAULT : 8'($urandom));
            k = $urandom_range(3);
            pushed += k + 1;
            repeat (k) queue_enc_step();
            k = (per + 1 > TICK_RUN_MAX) ? TICK_RUN_MAX : per + 1;
            k = $urandom_range(k, 1);
            pushed += k;
            repeat (k) queue_tick();
         end else if (pick < 70) begin
            // ticks toward the timeout, at most TICK_RUN_MAX of them
            k = (tmo + 1 > TICK_RUN_MAX) ? TICK_RUN_MAX : tmo + 1;
            pushed += k;
            repeat (k) queue_tick();
         end else if (pick < 80) begin
            queue_cmd(8'($urandom));
            queue_cmd(8'($urandom));
            pushed += 2;
         end else if (pick < 90) begin
            gen_lines = 2'($urandom);
            queue_enc(gen_lines[1], gen_lines[0]);
            pushed++;
         end else begin
            queue_event(2'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
            pushed++;
         end
      end
   endtask

   task automatic write_reg(input logic idx, input logic [7:0] value);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (idx == CSR_FRAME_PERIOD) period_ms = value;
      else timeout_lim = value;
   endtask

   // Drain everything, then allow for an item still in the front end with no result
   task automatic wait_idle();
      while (events_in_flight != 0 || beats_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int per_tbl[NUM_PHASES]   = '{2, 20, 3, 1, 255, 0, 6, 4};
      int tmo_tbl[NUM_PHASES]   = '{3, 50, 5, 255, 1, 0, 12, 9};
      int send_tbl[NUM_PHASES]  = '{0, 0, 72, 0, 11, 0, 11, 0};
      int recv_tbl[NUM_PHASES]  = '{0, 0, 0, 72, 11, 0, 11, 72};
      int items_tbl[NUM_PHASES] = '{0, 50, 50, 30, 30, 20, 50, 40};
      link_model_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_reg(CSR_FRAME_PERIOD, 8'(per_tbl[p]));
         write_reg(CSR_TIMEOUT, 8'(tmo_tbl[p]));
         send_idle_pct = send_tbl[p];
         recv_stall_pct = recv_tbl[p];
         if (p == 0) begin
            // unused mode still fires the frame start pending from reset
            queue_event(MODE_UNUSED, 1'b1, 1'b1, 8'hA5);
            queue_enc(1'b0, 1'b1);     // down from zero, position wraps
            queue_enc(1'b0, 1'b0);
            queue_enc(1'b1, 1'b1);     // both lines changed
            queue_enc(1'b1, 1'b0);
            queue_enc(1'b1, 1'b1);
            queue_cmd(CMD_CLEAR_FAULT); // early command, fault cleared at frame
            queue_tick();
            queue_tick();
            queue_cmd(8'hFF);
            queue_tick();
            queue_tick();
            queue_cmd(8'h7F);
            queue_cmd(8'h55);          // goes to the hold slot
            queue_cmd(8'hAA);          // slot full, dropped
            queue_tick();
            queue_tick();
            queue_tick();
            queue_tick();
            repeat (3) queue_tick();   // no command: timeout
            queue_cmd(8'h01);          // discarded after timeout
            queue_tick();
            queue_tick();
            queue_tick();
            queue_cmd(CMD_CLEAR_FAULT); // late command
            queue_tick();
         end else begin
            if (p == 6) holdoff_asked++;
            queue_traffic(items_tbl[p], per_tbl[p], tmo_tbl[p]);
         end
         wait_idle();
      end

      if (beats_due.size() != 0) flag_error("results never sent, count", beats_due.size(), 0);
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
